[hw/rtl/two_stack_queue_top_macros.svh]
// ---------------------------------------------------------------------------
// Two-stack queue assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef TWO_STACK_QUEUE_TOP_MACROS_SVH
`define TWO_STACK_QUEUE_TOP_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define TSQ_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("two_stack_queue invariant violated");

// When the antecedent holds, the consequent holds in the next cycle.
`define TSQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("two_stack_queue sequence violated");

`endif

[hw/rtl/tsq_pkg.sv]
// ---------------------------------------------------------------------------
// tsq_pkg
// Types and constants shared by the two-stack queue modules.
// ---------------------------------------------------------------------------
package tsq_pkg;

    localparam int DATA_W      = 32;
    localparam int CAP_W       = 7;
    localparam int STATUS_W    = 3;
    localparam int MOVED_W     = 7;
    localparam int IN_DEPTH_DEF  = 64;
    localparam int OUT_DEPTH_DEF = 64;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Configuration register indexes.
    localparam logic REG_ENQ_CAP = 1'b0;
    localparam logic REG_DEQ_CAP = 1'b1;

    // Commands.
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ENQ  = 3'd0,
        ST_DEQ  = 3'd1,
        ST_OVF  = 3'd2,
        ST_UNF  = 3'd3,
        ST_LACK = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_MOVE,
        S_POP
    } state_t;

endpackage

[hw/rtl/tsq_stack_ram.sv]
// ---------------------------------------------------------------------------
// tsq_stack_ram
// Storage for one stack: one write port and one registered read port.
// ---------------------------------------------------------------------------
module tsq_stack_ram #(
    parameter int DEPTH = tsq_pkg::IN_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [tsq_pkg::DATA_W-1:0] wdata,
    input  logic [AW-1:0]              raddr,
    output logic [tsq_pkg::DATA_W-1:0] rdata
);

    logic [tsq_pkg::DATA_W-1:0] mem [DEPTH];
    logic [tsq_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/two_stack_queue_top.sv]
// ---------------------------------------------------------------------------
// two_stack_queue_top
// FIFO queue built from an input stack and an output stack in two RAMs.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low: command 0 pushes
// value, command 1 pops the oldest word. Each request gives one result on
// status, data and moved, shown for one cycle while done is high; the
// receiver cannot stall it. busy stays high from acceptance until the
// result is registered, so one request is in the block at a time.
// A push without a move is answered from the evaluate state; a pop reads
// the output RAM there and is answered from the pop state after it. When
// the input stack has to be reversed into the output stack, the move
// copies one word per cycle through the input RAM's read port and the
// output RAM's write port, and the request is then evaluated again. Each
// word is moved at most once. The capacities are written through cfg_we,
// cfg_index and cfg_wdata; the user must do so only while the block is
// idle; the block itself does not enforce it. Reset empties both stacks
// and sets both capacities to 64; stack contents are not cleared.
// ---------------------------------------------------------------------------
`include "two_stack_queue_top_macros.svh"

module two_stack_queue_top #(
    parameter int IN_DEPTH  = tsq_pkg::IN_DEPTH_DEF,
    parameter int OUT_DEPTH = tsq_pkg::OUT_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               command,
    input  logic signed [tsq_pkg::DATA_W-1:0]  value,
    output logic                               done,
    output logic [tsq_pkg::STATUS_W-1:0]       status,
    output logic signed [tsq_pkg::DATA_W-1:0]  data,
    output logic [tsq_pkg::MOVED_W-1:0]        moved,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [tsq_pkg::CAP_W-1:0]          cfg_wdata
);

    localparam int IN_CW  = $clog2(IN_DEPTH + 1);
    localparam int OUT_CW = $clog2(OUT_DEPTH + 1);
    localparam int IN_AW  = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
    localparam int OUT_AW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int CMPW   = (IN_CW > OUT_CW) ? IN_CW : OUT_CW;
    localparam int DW     = tsq_pkg::DATA_W;

    localparam logic [IN_CW-1:0]  IN_DEPTH_C  = IN_CW'(IN_DEPTH);
    localparam logic [OUT_CW-1:0] OUT_DEPTH_C = OUT_CW'(OUT_DEPTH);

    tsq_pkg::state_t  state_reg, state_next;

    logic [tsq_pkg::CAP_W-1:0] enq_cap_reg, deq_cap_reg;
    logic [IN_CW-1:0]          in_count_reg, in_count_next;
    logic [OUT_CW-1:0]         out_count_reg, out_count_next;
    logic                      cmd_reg;
    logic [DW-1:0]             val_reg;
    logic [tsq_pkg::MOVED_W-1:0] mv_reg, mv_next;
    logic [IN_CW-1:0]          rd_cnt_reg, rd_cnt_next;
    logic [IN_CW-1:0]          wr_cnt_reg, wr_cnt_next;
    logic                      rd_vld_reg, rd_vld_next;

    logic                      done_reg, done_next;
    tsq_pkg::status_t          status_reg, status_next;
    logic [DW-1:0]             data_reg, data_next;
    logic [tsq_pkg::MOVED_W-1:0] moved_reg, moved_next;

    logic [IN_CW-1:0]  in_cap;
    logic [OUT_CW-1:0] out_cap;
    logic              in_full, in_empty, out_empty, move_fits;
    logic              accept, rd_go, last_wr;

    logic              in_we, out_we;
    logic [IN_AW-1:0]  in_waddr, in_raddr;
    logic [OUT_AW-1:0] out_waddr, out_raddr;
    logic [DW-1:0]     in_wdata, out_wdata, in_rdata, out_rdata;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enq_cap_reg <= tsq_pkg::CAP_RESET;
            deq_cap_reg <= tsq_pkg::CAP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tsq_pkg::REG_ENQ_CAP: enq_cap_reg <= cfg_wdata;
                tsq_pkg::REG_DEQ_CAP: deq_cap_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // A capacity of zero acts as one; any value above the depth acts as the depth.
    always_comb
    begin
        if (enq_cap_reg == '0)
            in_cap = IN_CW'(1);
        else if (enq_cap_reg > IN_DEPTH)
            in_cap = IN_DEPTH_C;
        else
            in_cap = IN_CW'(enq_cap_reg);

        if (deq_cap_reg == '0)
            out_cap = OUT_CW'(1);
        else if (deq_cap_reg > OUT_DEPTH)
            out_cap = OUT_DEPTH_C;
        else
            out_cap = OUT_CW'(deq_cap_reg);
    end

    assign in_full   = (in_count_reg >= in_cap);
    assign in_empty  = (in_count_reg == '0);
    assign out_empty = (out_count_reg == '0);
    assign move_fits = (CMPW'(in_count_reg) <= CMPW'(out_cap));
    assign accept    = start && (state_reg == tsq_pkg::S_IDLE);
    assign busy      = (state_reg != tsq_pkg::S_IDLE);

    // The move walks the input stack from the top down while filling the
    // output stack from the bottom up; each write comes in the cycle after its read.
    assign rd_go   = (rd_cnt_reg != in_count_reg);
    assign last_wr = rd_vld_reg && (wr_cnt_reg == in_count_reg - IN_CW'(1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tsq_pkg::S_IDLE:
            begin
                if (start)
                    state_next = tsq_pkg::S_EVAL;
            end
            tsq_pkg::S_EVAL:
            begin
                state_next = tsq_pkg::S_IDLE;
                if (cmd_reg == tsq_pkg::CMD_ENQ)
                begin
                    if (in_full && out_empty && move_fits)
                        state_next = tsq_pkg::S_MOVE;
                end
                else if (!(in_empty && out_empty))
                begin
                    if (!out_empty)
                        state_next = tsq_pkg::S_POP;
                    else if (move_fits)
                        state_next = tsq_pkg::S_MOVE;
                end
            end
            tsq_pkg::S_MOVE:
            begin
                if (last_wr)
                    state_next = tsq_pkg::S_EVAL;
            end
            tsq_pkg::S_POP:
            begin
                state_next = tsq_pkg::S_IDLE;
            end
            default:
            begin
                state_next = tsq_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and result outputs.
    always_comb
    begin
        in_count_next  = in_count_reg;
        out_count_next = out_count_reg;
        mv_next        = mv_reg;
        rd_cnt_next    = rd_cnt_reg;
        wr_cnt_next    = wr_cnt_reg;
        rd_vld_next    = 1'b0;
        done_next      = 1'b0;
        status_next    = status_reg;
        data_next      = data_reg;
        moved_next     = moved_reg;
        in_we          = 1'b0;
        out_we         = 1'b0;
        in_waddr       = in_count_reg[IN_AW-1:0];
        in_wdata       = val_reg;
        in_raddr       = IN_AW'(in_count_reg - IN_CW'(1) - rd_cnt_reg);
        out_waddr      = OUT_AW'(wr_cnt_reg);
        out_wdata      = in_rdata;
        out_raddr      = OUT_AW'(out_count_reg - OUT_CW'(1));

        case (state_reg)
            tsq_pkg::S_IDLE:
            begin
                if (accept)
                    mv_next = '0;
            end
            tsq_pkg::S_EVAL:
            begin
                rd_cnt_next = '0;
                wr_cnt_next = '0;
                if (cmd_reg == tsq_pkg::CMD_ENQ)
                begin
                    if (in_full && !out_empty)
                    begin
                        done_next   = 1'b1;
                        status_next = tsq_pkg::ST_OVF;
                        data_next   = '0;
                        moved_next  = '0;
                    end
                    else if (in_full && !move_fits)
                    begin
                        done_next   = 1'b1;
                        status_next = tsq_pkg::ST_LACK;
                        data_next   = '0;
                        moved_next  = '0;
                    end
                    else if (!in_full)
                    begin
                        in_we         = 1'b1;
                        in_count_next = in_count_reg + IN_CW'(1);
                        done_next     = 1'b1;
                        status_next   = tsq_pkg::ST_ENQ;
                        data_next     = val_reg;
                        moved_next    = mv_reg;
                    end
                end
                else
                begin
                    if (in_empty && out_empty)
                    begin
                        done_next   = 1'b1;
                        status_next = tsq_pkg::ST_UNF;
                        data_next   = '0;
                        moved_next  = '0;
                    end
                    else if (out_empty && !move_fits)
                    begin
                        done_next   = 1'b1;
                        status_next = tsq_pkg::ST_LACK;
                        data_next   = '0;
                        moved_next  = '0;
                    end
                    else if (!out_empty)
                    begin
                        // The read of the top entry is issued here.
                        out_count_next = out_count_reg - OUT_CW'(1);
                    end
                end
            end
            tsq_pkg::S_MOVE:
            begin
                if (rd_go)
                begin
                    rd_cnt_next = rd_cnt_reg + IN_CW'(1);
                    rd_vld_next = 1'b1;
                end
                if (rd_vld_reg)
                begin
                    out_we      = 1'b1;
                    wr_cnt_next = wr_cnt_reg + IN_CW'(1);
                end
                if (last_wr)
                begin
                    out_count_next = OUT_CW'(in_count_reg);
                    in_count_next  = '0;
                    mv_next        = tsq_pkg::MOVED_W'(in_count_reg);
                end
            end
            tsq_pkg::S_POP:
            begin
                done_next   = 1'b1;
                status_next = tsq_pkg::ST_DEQ;
                data_next   = out_rdata;
                moved_next  = mv_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tsq_pkg::S_IDLE;
            in_count_reg  <= '0;
            out_count_reg <= '0;
            rd_vld_reg    <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_count_reg  <= in_count_next;
            out_count_reg <= out_count_next;
            rd_vld_reg    <= rd_vld_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command;
            val_reg <= value;
        end
        mv_reg     <= mv_next;
        rd_cnt_reg <= rd_cnt_next;
        wr_cnt_reg <= wr_cnt_next;
        status_reg <= status_next;
        data_reg   <= data_next;
        moved_reg  <= moved_next;
    end

    tsq_stack_ram #(
        .DEPTH (IN_DEPTH),
        .AW    (IN_AW)
    ) u_in_ram (
        .clk   (clk),
        .we    (in_we),
        .waddr (in_waddr),
        .wdata (in_wdata),
        .raddr (in_raddr),
        .rdata (in_rdata)
    );

    tsq_stack_ram #(
        .DEPTH (OUT_DEPTH),
        .AW    (OUT_AW)
    ) u_out_ram (
        .clk   (clk),
        .we    (out_we),
        .waddr (out_waddr),
        .wdata (out_wdata),
        .raddr (out_raddr),
        .rdata (out_rdata)
    );

    assign done   = done_reg;
    assign status = status_reg;
    assign data   = data_reg;
    assign moved  = moved_reg;

    `TSQ_ASSERT_ALWAYS(a_in_count_bound, in_count_reg <= IN_DEPTH_C)
    `TSQ_ASSERT_ALWAYS(a_move_onto_empty, (state_reg != tsq_pkg::S_MOVE) || out_empty)
    `TSQ_ASSERT_NEXT(a_done_single, done_reg, !done_reg)
    `TSQ_ASSERT_NEXT(a_accept_eval, accept, state_reg == tsq_pkg::S_EVAL)

endmodule

[test/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top: two-stack queue testbench
// Drives push and pop requests through the start/busy handshake and keeps
// its own copy of both stacks to predict every result. Results are checked
// field by field in order. The run includes short directed sequences for
// the corner cases, then random phases under several capacity settings,
// most of them with random gaps between requests.
// ---------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import tsq_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int NUM_PHASES  = 12;
    localparam int PHASE_REQS  = 107;

    typedef struct packed {
        logic              command;
        logic [DATA_W-1:0] value;
    } queue_req_t;

    typedef struct {
        status_t            status;
        logic [DATA_W-1:0]  data;
        logic [MOVED_W-1:0] moved;
    } queue_rsp_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic                       command = CMD_ENQ;
    logic signed [DATA_W-1:0]   value = '0;
    logic                       done;
    logic [STATUS_W-1:0]        status;
    logic signed [DATA_W-1:0]   data;
    logic [MOVED_W-1:0]         moved;
    logic                       cfg_we = 1'b0;
    logic                       cfg_index = REG_ENQ_CAP;
    logic [CAP_W-1:0]           cfg_wdata = '0;

    two_stack_queue_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .value     (value),
        .done      (done),
        .status    (status),
        .data      (data),
        .moved     (moved),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Shadow copy of the queue state and capacity registers.
    logic [DATA_W-1:0] in_words  [IN_DEPTH_DEF];
    logic [DATA_W-1:0] out_words [OUT_DEPTH_DEF];
    int                in_fill  = 0;
    int                out_fill = 0;
    logic [CAP_W-1:0]  enq_cap_reg = CAP_RESET;
    logic [CAP_W-1:0]  deq_cap_reg = CAP_RESET;

    queue_req_t pending_reqs[$];
    queue_rsp_t expected_results[$];

    logic taken = 1'b0;
    logic idle_on = 1'b1;
    int   gap_left = 0;
    logic drain_hold = 1'b0;
    int   errors = 0;
    int   reqs_taken = 0;
    int   results_checked = 0;
    int   status_seen [5] = '{default: 0};
    int   max_moved = 0;
    int   settings_used = 1;
    int   stall_cycles = 0;

    function automatic int usable_cap(logic [CAP_W-1:0] cap, int depth);
        if (cap == 0)
            return 1;
        return (cap > depth) ? depth : int'(cap);
    endfunction

    // Reverse the input stack onto the empty output stack; refuse if too big.
    function automatic bit transfer_stacks(output int count);
        int n;
        n = in_fill;
        count = 0;
        if (n > usable_cap(deq_cap_reg, OUT_DEPTH_DEF) || out_fill != 0)
            return 1'b0;
        for (int k = 0; k < n; k++)
            out_words[k] = in_words[n - 1 - k];
        out_fill = n;
        in_fill = 0;
        count = n;
        return 1'b1;
    endfunction

    function automatic queue_rsp_t predict_queue_op(logic cmd, logic [DATA_W-1:0] val);
        queue_rsp_t rsp;
        int         count;
        count = 0;
        rsp.data = '0;
        rsp.moved = '0;
        if (cmd == CMD_ENQ)
        begin
            if (in_fill >= usable_cap(enq_cap_reg, IN_DEPTH_DEF))
            begin
                if (out_fill != 0)
                begin
                    rsp.status = ST_OVF;
                    return rsp;
                end
                if (!transfer_stacks(count))
                begin
                    rsp.status = ST_LACK;
                    return rsp;
                end
            end
            in_words[in_fill] = val;
            in_fill++;
            rsp.status = ST_ENQ;
            rsp.data = val;
            rsp.moved = count[MOVED_W-1:0];
            return rsp;
        end
        if (in_fill == 0 && out_fill == 0)
        begin
            rsp.status = ST_UNF;
            return rsp;
        end
        if (out_fill == 0 && !transfer_stacks(count))
        begin
            rsp.status = ST_LACK;
            return rsp;
        end
        out_fill--;
        rsp.status = ST_DEQ;
        rsp.data = out_words[out_fill];
        rsp.moved = count[MOVED_W-1:0];
        return rsp;
    endfunction

    function automatic queue_req_t random_req(int enq_pct);
        queue_req_t req;
        req.command = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
        case ($urandom_range(0, 9))
            0:       req.value = 32'h8000_0000;
            1:       req.value = 32'h7fff_ffff;
            2:       req.value = '0;
            3:       req.value = '1;
            default: req.value = $urandom;
        endcase
        return req;
    endfunction

    task automatic add_req(logic cmd, logic [DATA_W-1:0] val);
        pending_reqs.push_back('{command: cmd, value: val});
    endtask

    task automatic write_cap(logic idx, logic [CAP_W-1:0] cap);
        @(negedge clk);
        cfg_index <= idx;
        cfg_wdata <= cap;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_ENQ_CAP)
            enq_cap_reg = cap;
        else
            deq_cap_reg = cap;
    endtask

    // Returns once every request has been sent and every result has come.
    task automatic wait_idle();
        @(posedge clk);
        while (pending_reqs.size() != 0 || start || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Request driver: inputs change on the falling edge.
    always @(negedge clk)
    begin : driver
        queue_req_t nxt;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || taken)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end
            else if (drain_hold && expected_results.size() != 0)
            begin
                start <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                nxt = pending_reqs.pop_front();
                command    <= nxt.command;
                value      <= nxt.value;
                start      <= 1'b1;
                gap_left   <= idle_on ? $urandom_range(0, 7) : 0;
                drain_hold <= ($urandom_range(0, 39) == 0);
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Result checker and request predictor, sampled on the rising edge.
    always @(posedge clk)
    begin : monitor
        queue_rsp_t want;
        if (!rst_n)
        begin
            taken <= 1'b0;
        end
        else
        begin
            taken <= start && !busy;
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request outstanding: status %0d data %h moved %0d",
                           status, data, moved);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        errors++;
                    end
                    if (data !== want.data)
                    begin
                        $error("data: expected %h, actual %h", want.data, data);
                        errors++;
                    end
                    if (moved !== want.moved)
                    begin
                        $error("moved: expected %0d, actual %0d", want.moved, moved);
                        errors++;
                    end
                    results_checked++;
                    status_seen[want.status]++;
                    if (want.moved > max_moved)
                        max_moved = want.moved;
                end
            end
            if (start && !busy)
            begin
                expected_results.push_back(predict_queue_op(command, value));
                reqs_taken++;
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $error("no request or result for %0d cycles", STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [CAP_W-1:0] enq_caps [7];
        logic [CAP_W-1:0] deq_caps [7];
        int               enq_pct;
        enq_caps = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd4, 7'd8, 7'd64};
        deq_caps = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd8, 7'd4, 7'd16};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset capacities: underflow, extreme words, a move on the first successful pop.
        add_req(CMD_DEQ, 32'h0);
        add_req(CMD_ENQ, 32'h8000_0000);
        add_req(CMD_ENQ, 32'h7fff_ffff);
        add_req(CMD_ENQ, 32'h0000_0000);
        add_req(CMD_ENQ, 32'hffff_ffff);
        add_req(CMD_DEQ, 32'h1234_5678);
        add_req(CMD_ENQ, 32'h5555_5555);
        add_req(CMD_DEQ, 32'h0);
        add_req(CMD_DEQ, 32'h0);
        add_req(CMD_DEQ, 32'h0);
        add_req(CMD_DEQ, 32'h0);
        add_req(CMD_DEQ, 32'h0);
        wait_idle();

        // A full input stack that does not fit the output stack: no room.
        write_cap(REG_ENQ_CAP, 7'd3);
        write_cap(REG_DEQ_CAP, 7'd2);
        settings_used++;
        add_req(CMD_ENQ, 32'haaaa_aaaa);
        add_req(CMD_ENQ, 32'h1);
        add_req(CMD_ENQ, 32'h2);
        add_req(CMD_ENQ, 32'h3);
        add_req(CMD_DEQ, 32'h0);
        wait_idle();

        // Out-of-range capacities clamp; overflow with the output side busy.
        write_cap(REG_DEQ_CAP, 7'd127);
        write_cap(REG_ENQ_CAP, 7'd0);
        settings_used++;
        add_req(CMD_DEQ, 32'h0);
        add_req(CMD_ENQ, 32'h4);
        add_req(CMD_ENQ, 32'h5);
        add_req(CMD_DEQ, 32'h0);
        add_req(CMD_DEQ, 32'h0);
        add_req(CMD_DEQ, 32'h0);
        wait_idle();

        // Random phases; stored words carry over, so lowered capacities
        // regularly leave a stack filled beyond its limit.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p < 7)
            begin
                write_cap(REG_ENQ_CAP, enq_caps[p]);
                write_cap(REG_DEQ_CAP, deq_caps[p]);
            end
            else
            begin
                write_cap(REG_ENQ_CAP, CAP_W'($urandom_range(0, 127)));
                write_cap(REG_DEQ_CAP, CAP_W'($urandom_range(0, 127)));
            end
            settings_used++;
            idle_on = (p % 3 != 2);
            enq_pct = (p % 3 == 0) ? 70 : ((p % 3 == 1) ? 50 : 35);
            for (int i = 0; i < PHASE_REQS; i++)
                pending_reqs.push_back(random_req(enq_pct));
            wait_idle();
        end

        repeat (10) @(posedge clk);
        $display("%0d requests over %0d capacity settings, %0d results checked",
                 reqs_taken, settings_used, results_checked);
        $display("push %0d, pop %0d, overflow %0d, underflow %0d, no room %0d, longest move %0d",
                 status_seen[ST_ENQ], status_seen[ST_DEQ], status_seen[ST_OVF],
                 status_seen[ST_UNF], status_seen[ST_LACK], max_moved);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
